// File: sv/can_frame_text_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// can frame text parser assertion macros
// shared property wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_TEXT_PARSER_UNIT_DEFINES_SVH
`define CAN_FRAME_TEXT_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define CFTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define CFTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFTP_ASSERT_NOW(lbl, ante, cons, msg)
`define CFTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/cftp_pkg.sv
// ----------------------------------------------------------------------------
// cftp_pkg
// types, codes and helpers of the can frame text parser
// ----------------------------------------------------------------------------
package cftp_pkg;

  localparam int FD_MAX_BYTES_DEF      = 64;
  localparam int CLASSIC_MAX_BYTES_DEF = 8;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_R_UP  = 8'h52;
  localparam logic [7:0] CH_R_LOW = 8'h72;

  localparam logic [4:0] HEX_BAD     = 5'd16;
  localparam logic [4:0] REMOTE_MAX  = 5'd8;
  localparam logic [3:0] SHORT_ID_LEN = 4'd3;
  localparam logic [3:0] LONG_ID_LEN  = 4'd8;

  localparam logic [31:0] FLAG_EXT = 32'h8000_0000;
  localparam logic [31:0] FLAG_RTR = 32'h4000_0000;
  localparam logic [31:0] FLAG_ERR = 32'h2000_0000;
  localparam logic [31:0] SHORT_ID_MASK = 32'h0000_0FFF;

  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_CLASSIC = 2'd1;
  localparam logic [1:0] ST_FD      = 2'd2;

  typedef enum logic [2:0] {
    PH_ID,
    PH_AFTER_ID,
    PH_REMOTE,
    PH_FD_FLAGS,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [1:0]  status;
    logic [31:0] can_ident;
    logic [6:0]  frame_len;
    logic [3:0]  fd_flags;
  } result_t;

  // hex digit value, HEX_BAD for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

endpackage

// File: sv/cftp_in_stage.sv
// ----------------------------------------------------------------------------
// cftp_in_stage
// input register holding one character beat until the parser takes it
// ----------------------------------------------------------------------------
module cftp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // character
  input  logic           in_tlast,   // is_last
  input  logic           advance,
  output logic           item_valid,
  output cftp_pkg::item_t item
);
  import cftp_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{character: in_tdata, is_last: in_tlast};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: sv/cftp_parser.sv
// ----------------------------------------------------------------------------
// cftp_parser
// frame text state machine, one character per step
// ----------------------------------------------------------------------------
`include "can_frame_text_parser_unit_defines.svh"

module cftp_parser #(
  parameter int FD_MAX_BYTES      = cftp_pkg::FD_MAX_BYTES_DEF,
  parameter int CLASSIC_MAX_BYTES = cftp_pkg::CLASSIC_MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cftp_pkg::item_t   item,
  output logic              res_want,
  output logic              res_valid,
  output cftp_pkg::result_t res
);
  import cftp_pkg::*;

  localparam logic [6:0] FD_LIM      = 7'(FD_MAX_BYTES);
  localparam logic [6:0] CLASSIC_LIM = 7'(CLASSIC_MAX_BYTES);

  phase_t      phase_r,      phase_nxt;
  logic [3:0]  char_pos_r,   char_pos_nxt;
  logic [31:0] id_r,         id_nxt;
  logic [3:0]  high_nib_r,   high_nib_nxt;
  logic        nib_pend_r,   nib_pend_nxt;
  logic [6:0]  byte_cnt_r,   byte_cnt_nxt;
  logic        fd_mode_r,    fd_mode_nxt;
  logic [3:0]  flags_r,      flags_nxt;
  logic [3:0]  remote_len_r, remote_len_nxt;
  logic        err_r,        err_nxt;
  logic        dot_taken_r,  dot_taken_nxt;
  logic        is_remote_r,  is_remote_nxt;

  logic [7:0] c;
  logic [4:0] hex_n;
  logic       hex_ok;
  logic       do_data;
  logic       got;
  logic       dc_dot;
  logic [6:0] dc_cnt;
  logic [6:0] limit;
  logic       sum_ok;

  assign c      = item.character;
  assign hex_n  = hex_value(c);
  assign hex_ok = !hex_n[4];
  assign dc_dot = !nib_pend_r && (c == CH_DOT) && !dot_taken_r;
  assign dc_cnt = byte_cnt_r + 7'd1;
  assign limit  = fd_mode_r ? FD_LIM : CLASSIC_LIM;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    char_pos_nxt   = char_pos_r;
    id_nxt         = id_r;
    high_nib_nxt   = high_nib_r;
    nib_pend_nxt   = nib_pend_r;
    byte_cnt_nxt   = byte_cnt_r;
    fd_mode_nxt    = fd_mode_r;
    flags_nxt      = flags_r;
    remote_len_nxt = remote_len_r;
    err_nxt        = err_r;
    dot_taken_nxt  = dot_taken_r;
    is_remote_nxt  = is_remote_r;
    do_data        = 1'b0;
    got            = 1'b0;

    case (phase_r)
      PH_ID: begin
        if (char_pos_r == SHORT_ID_LEN && c == CH_HASH) begin
          id_nxt    = id_r & SHORT_ID_MASK;
          phase_nxt = PH_AFTER_ID;
        end else if (char_pos_r >= LONG_ID_LEN) begin
          if (c == CH_HASH) begin
            id_nxt    = ((id_r & FLAG_ERR) == '0) ? (id_r | FLAG_EXT) : id_r;
            phase_nxt = PH_AFTER_ID;
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end
        end else if (!hex_ok) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          id_nxt       = {id_r[27:0], hex_n[3:0]};
          char_pos_nxt = char_pos_r + 4'd1;
        end
      end
      PH_AFTER_ID: begin
        if (c == CH_R_UP || c == CH_R_LOW) begin
          is_remote_nxt = 1'b1;
          phase_nxt     = PH_REMOTE;
        end else if (c == CH_HASH) begin
          phase_nxt = PH_FD_FLAGS;
        end else begin
          phase_nxt = PH_DATA;
          do_data   = 1'b1;
        end
      end
      PH_REMOTE: begin
        if (hex_n <= REMOTE_MAX) begin
          remote_len_nxt = hex_n[3:0];
        end
        phase_nxt = PH_DONE;
      end
      PH_FD_FLAGS: begin
        if (!hex_ok) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          flags_nxt   = hex_n[3:0];
          fd_mode_nxt = 1'b1;
          phase_nxt   = PH_DATA;
        end
      end
      PH_DATA: begin
        do_data = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_data) begin
      if (dc_dot) begin
        dot_taken_nxt = 1'b1;
      end else if (!hex_ok) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_DONE;
      end else if (!nib_pend_r) begin
        high_nib_nxt = hex_n[3:0];
        nib_pend_nxt = 1'b1;
      end else begin
        byte_cnt_nxt  = dc_cnt;
        nib_pend_nxt  = 1'b0;
        dot_taken_nxt = 1'b0;
        got           = 1'b1;
        if (dc_cnt >= limit) begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  // outputs
  always_comb begin
    sum_ok = !err_nxt && phase_nxt != PH_ID && phase_nxt != PH_FD_FLAGS &&
             !(phase_nxt == PH_DATA && nib_pend_nxt);
    res       = '0;
    res_want  = got || item.is_last;
    res_valid = step && res_want;
    if (got) begin
      res.data_byte  = {high_nib_r, hex_n[3:0]};
      res.byte_index = byte_cnt_r[5:0];
    end
    if (item.is_last) begin
      res.kind = KIND_SUMMARY;
      if (sum_ok) begin
        res.status    = fd_mode_nxt ? ST_FD : ST_CLASSIC;
        res.can_ident = id_nxt | (is_remote_nxt ? FLAG_RTR : '0);
        res.frame_len = is_remote_nxt ? {3'b000, remote_len_nxt} : byte_cnt_nxt;
        res.fd_flags  = flags_nxt;
      end
    end else begin
      res.kind = KIND_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      phase_r      <= PH_ID;
      char_pos_r   <= '0;
      id_r         <= '0;
      high_nib_r   <= '0;
      nib_pend_r   <= 1'b0;
      byte_cnt_r   <= '0;
      fd_mode_r    <= 1'b0;
      flags_r      <= '0;
      remote_len_r <= '0;
      err_r        <= 1'b0;
      dot_taken_r  <= 1'b0;
      is_remote_r  <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      char_pos_r   <= char_pos_nxt;
      id_r         <= id_nxt;
      high_nib_r   <= high_nib_nxt;
      nib_pend_r   <= nib_pend_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      fd_mode_r    <= fd_mode_nxt;
      flags_r      <= flags_nxt;
      remote_len_r <= remote_len_nxt;
      err_r        <= err_nxt;
      dot_taken_r  <= dot_taken_nxt;
      is_remote_r  <= is_remote_nxt;
    end
  end

  `CFTP_ASSERT_NEXT(a_last_restarts, step && item.is_last,
    phase_r == PH_ID && char_pos_r == '0 && byte_cnt_r == '0,
    "parser did not restart after last beat")
  `CFTP_ASSERT_NOW(a_data_below_limit, phase_r == PH_DATA,
    byte_cnt_r < (fd_mode_r ? FD_LIM : CLASSIC_LIM),
    "byte count reached limit in data phase")
  `CFTP_ASSERT_NOW(a_id_len, 1'b1, char_pos_r <= LONG_ID_LEN, "identifier position overran")
  `CFTP_ASSERT_NOW(a_invalid_summary_clear,
    res_valid && res.kind == KIND_SUMMARY && res.status == ST_INVALID,
    res.can_ident == '0 && res.frame_len == '0 && res.fd_flags == '0,
    "invalid summary carries frame fields")

endmodule

// File: sv/cftp_out_stage.sv
// ----------------------------------------------------------------------------
// cftp_out_stage
// result register driving the output stream
// ----------------------------------------------------------------------------
module cftp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cftp_pkg::result_t res,
  output logic              can_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // data_byte, byte_index, status, can_ident,
                                        // frame_len, fd_flags, zero fill
  output logic              out_tuser   // kind
);
  import cftp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'b00000, res_r.fd_flags, res_r.frame_len, res_r.can_ident,
                       res_r.status, res_r.byte_index, res_r.data_byte};

endmodule

// File: sv/can_frame_text_parser_unit.sv
// ----------------------------------------------------------------------------
// can_frame_text_parser_unit
// parses the text form of a can frame into data bytes and a frame summary
// ----------------------------------------------------------------------------
// in channel: one character per beat in in_tdata, in_tlast on the final
// character of the frame text. out channel: out_tuser low is a data byte with
// its index, high is the end-of-frame summary (status, id, length, fd flags);
// after an invalid summary the consumer drops the bytes of that frame.
// a character beat yields zero or one result beat.
// a result reaches the out channel through the input register and then the
// result register. throughput: one character per cycle unless a result is
// held back by out_tready, set by the combinational parser step between them.
// the input register refills in the cycle it hands its character on, and the
// result register loads in the cycle its beat is taken.
// reset clears both registers and returns the parser to the identifier phase;
// the parser also restarts by itself after each last character.
// when out_tready is low with a result waiting, a character that yields no
// result still passes; one that yields a result holds in the input register,
// and in_tready drops once that register is full.
// ----------------------------------------------------------------------------
module can_frame_text_parser_unit #(
  parameter int FD_MAX_BYTES      = cftp_pkg::FD_MAX_BYTES_DEF,
  parameter int CLASSIC_MAX_BYTES = cftp_pkg::CLASSIC_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // character
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // data_byte, byte_index, status, can_ident,
                                  // frame_len, fd_flags, zero fill
  output logic        out_tuser   // kind
);
  import cftp_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    res_want;
  logic    res_valid;
  result_t res;
  logic    can_take;
  logic    advance;

  // a character with no result never waits on the output side
  assign advance = item_valid && (can_take || !res_want);

  cftp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cftp_parser #(
    .FD_MAX_BYTES      (FD_MAX_BYTES),
    .CLASSIC_MAX_BYTES (CLASSIC_MAX_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .res_want  (res_want),
    .res_valid (res_valid),
    .res       (res)
  );

  cftp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
